[hdl/stt_pkg.sv]
package stt_pkg;

  localparam int NKW       = 27;
  localparam int KW_MAXLEN = 9;
  localparam int LEN_W     = 12;
  localparam int KIND_W    = 7;

  localparam int DEF_OFFSET_BITS = 20;
  localparam int DEF_LINE_BITS   = 16;
  localparam int DEF_COLUMN_BITS = 12;

  localparam logic [KIND_W-1:0] K_IDENT  = 7'd0;
  localparam logic [KIND_W-1:0] K_INT    = 7'd28;
  localparam logic [KIND_W-1:0] K_FLOAT  = 7'd29;
  localparam logic [KIND_W-1:0] K_CHAR   = 7'd30;
  localparam logic [KIND_W-1:0] K_STRING = 7'd31;
  localparam logic [KIND_W-1:0] K_PUNCT  = 7'd32;
  localparam logic [KIND_W-1:0] K_OPS    = 7'd43;
  localparam logic [KIND_W-1:0] K_AND2   = 7'd67;
  localparam logic [KIND_W-1:0] K_OR2    = 7'd68;

  localparam logic [3:0] OP_SLASH = 4'd8;
  localparam logic [3:0] OP_AMP   = 4'd9;
  localparam logic [3:0] OP_PIPE  = 4'd10;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_PIPE   = 8'h7C;

  // Keywords are left-aligned and padded with spaces; the padding is never compared.
  localparam logic [8*KW_MAXLEN-1:0] KW_STR [NKW] = '{
    "self     ", "if       ", "else     ", "while    ", "do       ", "for      ",
    "break    ", "return   ", "struct   ", "construct", "destruct ", "true     ",
    "false    ", "void     ", "bool     ", "char     ", "uchar    ", "short    ",
    "ushort   ", "int      ", "uint     ", "long     ", "ulong    ", "float    ",
    "double   ", "string   ", "extern   "
  };
  localparam logic [3:0] KW_LEN [NKW] = '{
    4'd4, 4'd2, 4'd4, 4'd5, 4'd2, 4'd3, 4'd5, 4'd6, 4'd6, 4'd9, 4'd8, 4'd4, 4'd5, 4'd4,
    4'd4, 4'd4, 4'd5, 4'd5, 4'd6, 4'd3, 4'd4, 4'd4, 4'd5, 4'd5, 4'd6, 4'd6, 4'd6
  };

  typedef enum logic [2:0] {
    M_IDLE, M_IDENT, M_NUMBER, M_COMMENT, M_CHAR_OPEN, M_CHAR_VALUE, M_STRING, M_OPERATOR
  } mode_e;

  typedef struct packed {
    mode_e            mode;
    logic [3:0]       pend_op;
    logic [NKW-1:0]   kw_match;
    logic [LEN_W-1:0] tok_len;
    logic             period;
    logic [7:0]       char_val;
  } lex_state_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [15:0]       line;
    logic [11:0]       scol;
    logic [11:0]       ecol;
    logic [19:0]       off;
    logic [11:0]       len;
    logic [7:0]        cval;
    logic              mal;
    logic              last;
  } tok_t;

  function automatic logic [NKW-1:0] ident_add(logic [NKW-1:0] m, logic [LEN_W-1:0] len,
                                               logic [7:0] c);
    logic [8*KW_MAXLEN-1:0] s;
    logic [NKW-1:0] r;
    r = m;
    for (int k = 0; k < NKW; k++) begin
      s = KW_STR[k] << (8 * len[3:0]);
      if (!((len < LEN_W'(KW_LEN[k])) && (s[8*KW_MAXLEN-1 -: 8] == c))) r[k] = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [KIND_W-1:0] ident_kind(logic [NKW-1:0] m, logic [LEN_W-1:0] len);
    logic [KIND_W-1:0] kd;
    kd = K_IDENT;
    for (int k = 0; k < NKW; k++) begin
      if (m[k] && len == LEN_W'(KW_LEN[k])) kd = KIND_W'(k + 1);
    end
    return kd;
  endfunction

  // Returns {hit, index}.
  function automatic logic [4:0] punct_code(logic [7:0] c);
    logic [4:0] r;
    unique case (c)
      8'h3B:   r = {1'b1, 4'd0};
      8'h28:   r = {1'b1, 4'd1};
      8'h29:   r = {1'b1, 4'd2};
      8'h5B:   r = {1'b1, 4'd3};
      8'h5D:   r = {1'b1, 4'd4};
      8'h7B:   r = {1'b1, 4'd5};
      8'h7D:   r = {1'b1, 4'd6};
      8'h7E:   r = {1'b1, 4'd7};
      8'h2C:   r = {1'b1, 4'd8};
      8'h3A:   r = {1'b1, 4'd9};
      8'h2E:   r = {1'b1, 4'd10};
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] op_code(logic [7:0] c);
    logic [4:0] r;
    unique case (c)
      8'h2B:   r = {1'b1, 4'd0};
      8'h2D:   r = {1'b1, 4'd1};
      8'h2A:   r = {1'b1, 4'd2};
      8'h25:   r = {1'b1, 4'd3};
      8'h3D:   r = {1'b1, 4'd4};
      8'h21:   r = {1'b1, 4'd5};
      8'h3C:   r = {1'b1, 4'd6};
      8'h3E:   r = {1'b1, 4'd7};
      8'h2F:   r = {1'b1, OP_SLASH};
      8'h26:   r = {1'b1, OP_AMP};
      8'h7C:   r = {1'b1, OP_PIPE};
      8'h5E:   r = {1'b1, 4'd11};
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

[hdl/source_text_tokenizer_top.sv]
// Channel   Dir  Beat contents
// s_axis    in   tdata[7:0] source byte, tlast end of source (byte ignored)
// m_axis    out  tdata token position fields, tuser kind and malformed flag,
//                tlast marks the last token caused by one input beat
//
// Each input beat is lexed by the lexer logic between the scan
// state registers and a four-entry token queue; a beat gives zero to two tokens.
// Input is taken every cycle while the queue has room for two tokens, so the
// rate is one beat per cycle as long as the output side drains.
// Reset is asynchronous and clears all scan state to the start of a source.
// An end-of-source beat also returns the state to that start.
module source_text_tokenizer_top #(
  parameter int OFFSET_BITS = stt_pkg::DEF_OFFSET_BITS,
  parameter int LINE_BITS   = stt_pkg::DEF_LINE_BITS,
  parameter int COLUMN_BITS = stt_pkg::DEF_COLUMN_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] source_byte
  input  logic        s_axis_tlast_i,   // end_marker
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [15:0] start_line, [27:16] start_column, [39:28] end_column,
  // [59:40] text_offset, [71:60] text_length, [79:72] char_value
  output logic [79:0] m_axis_tdata_o,
  output logic [7:0]  m_axis_tuser_o,   // [6:0] token_kind, [7] malformed
  output logic        m_axis_tlast_o    // last_of_run
);
  import stt_pkg::*;

  lex_state_t             st_q, st_d;
  logic [OFFSET_BITS-1:0] off_q, off_d, tso_q, tso_d;
  logic [LINE_BITS-1:0]   line_q, line_d, tsl_q, tsl_d;
  logic [COLUMN_BITS-1:0] col_q, col_d, tsc_q, tsc_d;
  tok_t                   r0, r1, head;
  logic [1:0]             nres;
  logic                   room, accept;

  assign s_axis_tready_o = room;
  assign accept          = s_axis_tvalid_i && room;

  stt_lex #(.OB(OFFSET_BITS), .LB(LINE_BITS), .CB(COLUMN_BITS)) u_lex (
    .st_i(st_q), .off_i(off_q), .line_i(line_q), .col_i(col_q),
    .tso_i(tso_q), .tsl_i(tsl_q), .tsc_i(tsc_q),
    .byte_i(s_axis_tdata_i), .eom_i(s_axis_tlast_i),
    .st_o(st_d), .off_o(off_d), .line_o(line_d), .col_o(col_d),
    .tso_o(tso_d), .tsl_o(tsl_d), .tsc_o(tsc_d),
    .res0_o(r0), .res1_o(r1), .nres_o(nres)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode     <= M_IDLE;
      st_q.pend_op  <= '0;
      st_q.kw_match <= '1;
      st_q.tok_len  <= '0;
      st_q.period   <= 1'b0;
      st_q.char_val <= '0;
      off_q  <= '0;
      line_q <= '0;
      col_q  <= COLUMN_BITS'(1);
      tso_q  <= '0;
      tsl_q  <= '0;
      tsc_q  <= COLUMN_BITS'(1);
    end else if (accept) begin
      st_q   <= st_d;
      off_q  <= off_d;
      line_q <= line_d;
      col_q  <= col_d;
      tso_q  <= tso_d;
      tsl_q  <= tsl_d;
      tsc_q  <= tsc_d;
    end
  end

  stt_outq #(.DEPTH(4)) u_outq (
    .clk_i, .rst_ni,
    .push_n_i(accept ? nres : 2'd0),
    .push0_i(r0), .push1_i(r1),
    .room_o(room),
    .valid_o(m_axis_tvalid_o),
    .pop_i(m_axis_tready_i),
    .head_o(head)
  );

  assign m_axis_tdata_o = {head.cval, head.len, head.off, head.ecol, head.scol, head.line};
  assign m_axis_tuser_o = {head.mal, head.kind};
  assign m_axis_tlast_o = head.last;

endmodule

[hdl/stt_lex.sv]
module stt_lex #(
  parameter int OB = 20,
  parameter int LB = 16,
  parameter int CB = 12
) (
  input  stt_pkg::lex_state_t st_i,
  input  logic [OB-1:0]       off_i,
  input  logic [LB-1:0]       line_i,
  input  logic [CB-1:0]       col_i,
  input  logic [OB-1:0]       tso_i,
  input  logic [LB-1:0]       tsl_i,
  input  logic [CB-1:0]       tsc_i,
  input  logic [7:0]          byte_i,
  input  logic                eom_i,
  output stt_pkg::lex_state_t st_o,
  output logic [OB-1:0]       off_o,
  output logic [LB-1:0]       line_o,
  output logic [CB-1:0]       col_o,
  output logic [OB-1:0]       tso_o,
  output logic [LB-1:0]       tsl_o,
  output logic [CB-1:0]       tsc_o,
  output stt_pkg::tok_t       res0_o,
  output stt_pkg::tok_t       res1_o,
  output logic [1:0]          nres_o
);
  import stt_pkg::*;

  function automatic tok_t mk(logic [KIND_W-1:0] kd, logic [LB-1:0] ln, logic [CB-1:0] sc,
                              logic [CB-1:0] ec, logic [OB-1:0] of, logic [LEN_W-1:0] le,
                              logic [7:0] cv, logic ml);
    tok_t t;
    t.kind = kd;
    t.line = 16'(ln);
    t.scol = 12'(sc);
    t.ecol = 12'(ec);
    t.off  = 20'(of);
    t.len  = le;
    t.cval = cv;
    t.mal  = ml;
    t.last = 1'b0;
    return t;
  endfunction

  logic [CB-1:0]    next_col;
  logic [OB-1:0]    off1;
  logic [7:0]       c;
  logic             is_alpha, is_digit, is_space, fresh;
  logic [4:0]       pc, oc;
  logic             a_v, b_v;
  tok_t             a_t, b_t;
  logic [KIND_W-1:0] id_kind, num_kind, op1_kind;

  always_comb begin
    c        = byte_i;
    next_col = (col_i == '1) ? col_i : col_i + CB'(1);
    off1     = (tso_i == '1) ? tso_i : tso_i + OB'(1);
    is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    is_digit = (c >= 8'h30 && c <= 8'h39);
    is_space = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    pc       = punct_code(c);
    oc       = op_code(c);
    id_kind  = ident_kind(st_i.kw_match, st_i.tok_len);
    num_kind = st_i.period ? K_FLOAT : K_INT;
    op1_kind = K_OPS + KIND_W'({st_i.pend_op, 1'b0});

    st_o   = st_i;
    off_o  = off_i;
    line_o = line_i;
    col_o  = col_i;
    tso_o  = tso_i;
    tsl_o  = tsl_i;
    tsc_o  = tsc_i;
    a_v    = 1'b0;
    b_v    = 1'b0;
    a_t    = '0;
    b_t    = '0;
    fresh  = 1'b0;

    if (eom_i) begin
      unique case (st_i.mode)
        M_IDENT: begin
          a_v = 1'b1;
          a_t = mk(id_kind, tsl_i, tsc_i, col_i, tso_i, st_i.tok_len, 8'd0, 1'b0);
        end
        M_NUMBER: begin
          a_v = 1'b1;
          a_t = mk(num_kind, tsl_i, tsc_i, col_i, tso_i, st_i.tok_len, 8'd0, 1'b0);
        end
        M_CHAR_OPEN: begin
          a_v = 1'b1;
          a_t = mk(K_CHAR, tsl_i, tsc_i, col_i, off1, '0, 8'd0, 1'b1);
        end
        M_CHAR_VALUE: begin
          a_v = 1'b1;
          a_t = mk(K_CHAR, tsl_i, tsc_i, col_i, off1, LEN_W'(1), st_i.char_val, 1'b1);
        end
        M_STRING: begin
          a_v = 1'b1;
          a_t = mk(K_STRING, tsl_i, tsc_i, col_i, off1, st_i.tok_len, 8'd0, 1'b1);
        end
        M_OPERATOR: begin
          a_v = 1'b1;
          a_t = mk(op1_kind, tsl_i, tsc_i, col_i, tso_i, LEN_W'(1), 8'd0, 1'b0);
        end
        default: ;
      endcase
      st_o.mode     = M_IDLE;
      st_o.pend_op  = '0;
      st_o.kw_match = '1;
      st_o.tok_len  = '0;
      st_o.period   = 1'b0;
      st_o.char_val = '0;
      off_o  = '0;
      line_o = '0;
      col_o  = CB'(1);
      tso_o  = '0;
      tsl_o  = '0;
      tsc_o  = CB'(1);
    end else begin
      unique case (st_i.mode)
        M_IDENT: begin
          if (is_alpha || is_digit || c == CH_UNDER) begin
            st_o.kw_match = ident_add(st_i.kw_match, st_i.tok_len, c);
            st_o.tok_len  = (st_i.tok_len == '1) ? st_i.tok_len : st_i.tok_len + LEN_W'(1);
          end else begin
            a_v   = 1'b1;
            a_t   = mk(id_kind, tsl_i, tsc_i, col_i, tso_i, st_i.tok_len, 8'd0, 1'b0);
            fresh = 1'b1;
          end
        end
        M_NUMBER: begin
          if (is_digit || (c == CH_PERIOD && !st_i.period)) begin
            if (!is_digit) st_o.period = 1'b1;
            st_o.tok_len = (st_i.tok_len == '1) ? st_i.tok_len : st_i.tok_len + LEN_W'(1);
          end else begin
            a_v   = 1'b1;
            a_t   = mk(num_kind, tsl_i, tsc_i, col_i, tso_i, st_i.tok_len, 8'd0, 1'b0);
            fresh = 1'b1;
          end
        end
        M_COMMENT: begin
          if (c == CH_NL) st_o.mode = M_IDLE;
        end
        M_CHAR_OPEN: begin
          st_o.char_val = c;
          st_o.mode     = M_CHAR_VALUE;
        end
        M_CHAR_VALUE: begin
          a_v = 1'b1;
          if (c == CH_QUOTE) begin
            a_t = mk(K_CHAR, tsl_i, tsc_i, next_col, off1, LEN_W'(1), st_i.char_val, 1'b0);
            st_o.mode = M_IDLE;
          end else begin
            a_t   = mk(K_CHAR, tsl_i, tsc_i, col_i, off1, LEN_W'(1), st_i.char_val, 1'b1);
            fresh = 1'b1;
          end
        end
        M_STRING: begin
          if (c == CH_DQUOTE) begin
            a_v = 1'b1;
            a_t = mk(K_STRING, tsl_i, tsc_i, next_col, off1, st_i.tok_len, 8'd0, 1'b0);
            st_o.mode = M_IDLE;
          end else begin
            st_o.tok_len = (st_i.tok_len == '1) ? st_i.tok_len : st_i.tok_len + LEN_W'(1);
          end
        end
        M_OPERATOR: begin
          priority if (st_i.pend_op == OP_SLASH && c == CH_SLASH) begin
            st_o.mode = M_COMMENT;
          end else if (c == CH_EQ) begin
            a_v = 1'b1;
            a_t = mk(op1_kind + KIND_W'(1), tsl_i, tsc_i, next_col, tso_i, LEN_W'(2),
                     8'd0, 1'b0);
            st_o.mode = M_IDLE;
          end else if (st_i.pend_op == OP_AMP && c == CH_AMP) begin
            a_v = 1'b1;
            a_t = mk(K_AND2, tsl_i, tsc_i, next_col, tso_i, LEN_W'(2), 8'd0, 1'b0);
            st_o.mode = M_IDLE;
          end else if (st_i.pend_op == OP_PIPE && c == CH_PIPE) begin
            a_v = 1'b1;
            a_t = mk(K_OR2, tsl_i, tsc_i, next_col, tso_i, LEN_W'(2), 8'd0, 1'b0);
            st_o.mode = M_IDLE;
          end else begin
            a_v   = 1'b1;
            a_t   = mk(op1_kind, tsl_i, tsc_i, col_i, tso_i, LEN_W'(1), 8'd0, 1'b0);
            fresh = 1'b1;
          end
        end
        default: fresh = 1'b1;
      endcase

      // The byte that ended a token is lexed again as the start of something new.
      if (fresh) begin
        st_o.mode = M_IDLE;
        priority if (is_alpha) begin
          tso_o = off_i; tsl_o = line_i; tsc_o = col_i;
          st_o.kw_match = ident_add('1, '0, c);
          st_o.tok_len  = LEN_W'(1);
          st_o.mode     = M_IDENT;
        end else if (is_digit) begin
          tso_o = off_i; tsl_o = line_i; tsc_o = col_i;
          st_o.tok_len = LEN_W'(1);
          st_o.period  = 1'b0;
          st_o.mode    = M_NUMBER;
        end else if (is_space) begin
          st_o.mode = M_IDLE;
        end else if (pc[4]) begin
          b_v = 1'b1;
          b_t = mk(K_PUNCT + KIND_W'(pc[3:0]), line_i, col_i, next_col, off_i, LEN_W'(1),
                   8'd0, 1'b0);
        end else if (oc[4]) begin
          tso_o = off_i; tsl_o = line_i; tsc_o = col_i;
          st_o.tok_len = '0;
          st_o.pend_op = oc[3:0];
          st_o.mode    = M_OPERATOR;
        end else if (c == CH_QUOTE) begin
          tso_o = off_i; tsl_o = line_i; tsc_o = col_i;
          st_o.tok_len  = '0;
          st_o.char_val = '0;
          st_o.mode     = M_CHAR_OPEN;
        end else if (c == CH_DQUOTE) begin
          tso_o = off_i; tsl_o = line_i; tsc_o = col_i;
          st_o.tok_len = '0;
          st_o.mode    = M_STRING;
        end
      end

      off_o = (off_i == '1) ? off_i : off_i + OB'(1);
      if (c == CH_NL) begin
        line_o = (line_i == '1) ? line_i : line_i + LB'(1);
        col_o  = CB'(1);
      end else begin
        col_o = next_col;
      end
    end

    nres_o = {1'b0, a_v} + {1'b0, b_v};
    res0_o = a_v ? a_t : b_t;
    res1_o = b_t;
    if (a_v && b_v) res1_o.last = 1'b1;
    else            res0_o.last = 1'b1;
  end

endmodule

[hdl/stt_outq.sv]
module stt_outq #(
  parameter int DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    push_n_i,
  input  stt_pkg::tok_t push0_i,
  input  stt_pkg::tok_t push1_i,
  output logic          room_o,
  output logic          valid_o,
  input  logic          pop_i,
  output stt_pkg::tok_t head_o
);
  import stt_pkg::*;

  localparam int AW = $clog2(DEPTH);

  tok_t            mem_q [DEPTH];
  logic [AW-1:0]   rd_q, wr_q;
  logic [AW:0]     cnt_q;
  logic            pop;

  assign pop     = pop_i && (cnt_q != '0);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign room_o  = (cnt_q <= (AW+1)'(DEPTH - 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (pop) rd_q <= rd_q + AW'(1);
      wr_q  <= wr_q + AW'(push_n_i);
      cnt_q <= cnt_q + (AW+1)'(push_n_i) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) mem_q[wr_q] <= push0_i;
    if (push_n_i == 2'd2) mem_q[wr_q + AW'(1)] <= push1_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_i != 2'd0) |-> (cnt_q <= (AW+1)'(DEPTH - 2)))
    else $error("token queue overflow");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(DEPTH))
    else $error("token queue count out of range");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_i == 2'd2 && !pop) |=> (cnt_q == $past(cnt_q) + (AW+1)'(2)))
    else $error("token queue count lost a double push");

endmodule

[sim/tb_source_text_tokenizer_top.sv]
module tb_source_text_tokenizer_top;
  import stt_pkg::*;

  typedef struct packed {
    logic [6:0]  kind;
    logic [15:0] line;
    logic [11:0] scol;
    logic [11:0] ecol;
    logic [19:0] off;
    logic [11:0] len;
    logic [7:0]  cval;
    logic        mal;
    logic        last;
  } token_rec_t;

  localparam int NKWS = 27;
  localparam int LENMAX = 4095;
  localparam int OFFMAX = (1 << 20) - 1;
  localparam int LINMAX = (1 << 16) - 1;
  localparam int COLMAX = (1 << 12) - 1;
  localparam int IDLE_LIMIT = 5000;

  class token_scoreboard;
    token_rec_t pending[$];
    int errors;

    // Lexer state mirrors the block.
    mode_e      mode;
    int         pop;
    logic [29:0] kwm;
    int t_off, t_line, t_col, t_len;
    int c_off, c_line, c_col;
    bit period;
    int cval;
    token_rec_t run[$];
    string kwords[NKWS];

    function new();
      kwords = '{"self", "if", "else", "while", "do", "for", "break", "return", "struct",
                 "construct", "destruct", "true", "false", "void", "bool", "char", "uchar",
                 "short", "ushort", "int", "uint", "long", "ulong", "float", "double",
                 "string", "extern"};
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      mode = M_IDLE; pop = 0; kwm = '1;
      t_off = 0; t_line = 0; t_col = 1; t_len = 0;
      c_off = 0; c_line = 0; c_col = 1; period = 0; cval = 0;
    endfunction

    function int sat(int v, int mx);
      return (v < mx) ? v + 1 : mx;
    endfunction

    function void push_tok(int kind, int line, int scol, int ecol, int off, int len,
                           int cv, bit mal);
      token_rec_t t;
      t.kind = 7'(kind); t.line = 16'(line); t.scol = 12'(scol); t.ecol = 12'(ecol);
      t.off = 20'(off); t.len = 12'(len); t.cval = 8'(cv); t.mal = mal; t.last = 1'b0;
      run.insert(run.size(), t);
    endfunction

    function void push_started(int kind, int ecol, int off, int len, int cv, bit mal);
      push_tok(kind, t_line, t_col, ecol, off, len, cv, mal);
    endfunction

    function void begin_token();
      t_off = c_off; t_line = c_line; t_col = c_col; t_len = 0;
    endfunction

    function void ident_grow(int c);
      string s;
      for (int k = 0; k < NKWS; k++) begin
        s = kwords[k];
        if (!(t_len < s.len() && s[t_len] == c)) kwm[k] = 1'b0;
      end
      t_len = sat(t_len, LENMAX);
    endfunction

    function void ident_done();
      int kind;
      kind = 0;
      for (int k = 0; k < NKWS; k++) if (kwm[k] && t_len == kwords[k].len()) kind = k + 1;
      push_started(kind, c_col, t_off, t_len, 0, 0);
    endfunction

    function int punct_idx(int c);
      string p;
      p = ";()[]{}~,:.";
      for (int i = 0; i < 11; i++) if (p[i] == c) return i;
      return -1;
    endfunction

    function int op_idx(int c);
      string p;
      p = "+-*%=!<>/&|^";
      for (int i = 0; i < 12; i++) if (p[i] == c) return i;
      return -1;
    endfunction

    function bit is_alpha(int c); return (c >= 97 && c <= 122) || (c >= 65 && c <= 90); endfunction
    function bit is_digit(int c); return c >= 48 && c <= 57; endfunction

    function void lex_new(int c);
      int i;
      mode = M_IDLE;
      if (is_alpha(c)) begin
        begin_token(); kwm = '1; ident_grow(c); mode = M_IDENT;
      end else if (is_digit(c)) begin
        begin_token(); t_len = 1; period = 0; mode = M_NUMBER;
      end else if (c == 32 || (c >= 9 && c <= 13)) begin
      end else if (punct_idx(c) >= 0) begin
        push_tok(K_PUNCT + punct_idx(c), c_line, c_col, sat(c_col, COLMAX), c_off, 1, 0, 0);
      end else if (op_idx(c) >= 0) begin
        begin_token(); pop = op_idx(c); mode = M_OPERATOR;
      end else if (c == CH_QUOTE) begin
        begin_token(); cval = 0; mode = M_CHAR_OPEN;
      end else if (c == CH_DQUOTE) begin
        begin_token(); mode = M_STRING;
      end
    endfunction

    // Predicts the tokens of one accepted input beat.
    function void note_input(logic [7:0] b, logic eos);
      int c, ncol, off1;
      bit fresh;
      c = b; ncol = sat(c_col, COLMAX); off1 = sat(t_off, OFFMAX); fresh = 0;
      run.delete();
      if (eos) begin
        case (mode)
          M_IDENT: ident_done();
          M_NUMBER: push_started(period ? K_FLOAT : K_INT, c_col, t_off, t_len, 0, 0);
          M_CHAR_OPEN: push_started(K_CHAR, c_col, off1, 0, 0, 1);
          M_CHAR_VALUE: push_started(K_CHAR, c_col, off1, 1, cval, 1);
          M_STRING: push_started(K_STRING, c_col, off1, t_len, 0, 1);
          M_OPERATOR: push_started(K_OPS + 2 * pop, c_col, t_off, 1, 0, 0);
          default: ;
        endcase
        clear_state();
      end else begin
        case (mode)
          M_IDENT:
            if (is_alpha(c) || is_digit(c) || c == CH_UNDER) ident_grow(c);
            else begin ident_done(); fresh = 1; end
          M_NUMBER:
            if (is_digit(c)) t_len = sat(t_len, LENMAX);
            else if (c == CH_PERIOD && !period) begin
              period = 1; t_len = sat(t_len, LENMAX);
            end else begin
              push_started(period ? K_FLOAT : K_INT, c_col, t_off, t_len, 0, 0);
              fresh = 1;
            end
          M_COMMENT: if (c == CH_NL) mode = M_IDLE;
          M_CHAR_OPEN: begin cval = c; mode = M_CHAR_VALUE; end
          M_CHAR_VALUE:
            if (c == CH_QUOTE) begin
              push_started(K_CHAR, ncol, off1, 1, cval, 0); mode = M_IDLE;
            end else begin
              push_started(K_CHAR, c_col, off1, 1, cval, 1); fresh = 1;
            end
          M_STRING:
            if (c == CH_DQUOTE) begin
              push_started(K_STRING, ncol, off1, t_len, 0, 0); mode = M_IDLE;
            end else t_len = sat(t_len, LENMAX);
          M_OPERATOR:
            if (pop == OP_SLASH && c == CH_SLASH) mode = M_COMMENT;
            else if (c == CH_EQ) begin
              push_started(K_OPS + 2 * pop + 1, ncol, t_off, 2, 0, 0); mode = M_IDLE;
            end else if (pop == OP_AMP && c == CH_AMP) begin
              push_started(K_AND2, ncol, t_off, 2, 0, 0); mode = M_IDLE;
            end else if (pop == OP_PIPE && c == CH_PIPE) begin
              push_started(K_OR2, ncol, t_off, 2, 0, 0); mode = M_IDLE;
            end else begin
              push_started(K_OPS + 2 * pop, c_col, t_off, 1, 0, 0); fresh = 1;
            end
          default: fresh = 1;
        endcase
        if (fresh) lex_new(c);
        c_off = sat(c_off, OFFMAX);
        if (c == CH_NL) begin
          c_line = sat(c_line, LINMAX); c_col = 1;
        end else c_col = ncol;
      end
      if (run.size() > 0) run[run.size() - 1].last = 1;
      foreach (run[i]) pending.insert(pending.size(), run[i]);
    endfunction

    function void check_token(logic [79:0] d, logic [7:0] u, logic l);
      token_rec_t e, a;
      a.line = d[15:0]; a.scol = d[27:16]; a.ecol = d[39:28]; a.off = d[59:40];
      a.len = d[71:60]; a.cval = d[79:72]; a.kind = u[6:0]; a.mal = u[7]; a.last = l;
      if (pending.size() == 0) begin
        $display("%0t: unexpected token kind %0d line %0d col %0d", $time, a.kind, a.line,
                 a.scol);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e != a) begin
        $display({"%0t: token mismatch expected kind=%0d line=%0d scol=%0d ecol=%0d",
                  " off=%0d len=%0d cv=%0d mal=%0d last=%0d"},
                 $time, e.kind, e.line, e.scol, e.ecol, e.off, e.len, e.cval, e.mal, e.last);
        $display({"%0t:                actual   kind=%0d line=%0d scol=%0d ecol=%0d",
                  " off=%0d len=%0d cv=%0d mal=%0d last=%0d"},
                 $time, a.kind, a.line, a.scol, a.ecol, a.off, a.len, a.cval, a.mal, a.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid_i, s_axis_tready_o, s_axis_tlast_i;
  logic [7:0]  s_axis_tdata_i;
  logic        m_axis_tvalid_o, m_axis_tready_i, m_axis_tlast_o;
  logic [79:0] m_axis_tdata_o;
  logic [7:0]  m_axis_tuser_o;

  source_text_tokenizer_top i_dut (.*);

  token_scoreboard lexer_sb;
  int send_idle_pct, recv_idle_pct;
  int idle_cycles;

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver side: random stalls, checking on accepted beats.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i)
        lexer_sb.check_token(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** source_text_tokenizer_top: FAILED **");
      $finish;
    end
  end

  // The valid stays high after a beat is taken; the next call either idles or
  // presents the following beat at once.
  task automatic send_byte(logic [7:0] b, logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= eos;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    lexer_sb.note_input(b, eos);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  function automatic logic [7:0] pick_byte();
    string alpha;
    alpha = "abcdefghilnorstuvwxyzABZ_0123456789.+-*%=!<>/&|^;()[]{}~,:'\" \n\t";
    case ($urandom_range(9))
      0: return 8'($urandom_range(255));
      default: return alpha[$urandom_range(alpha.len() - 1)];
    endcase
  endfunction

  task automatic random_phase(int count);
    string words[10];
    words = '{"while ", "return(", "construct", "x_1 ", "3.14.", "'a'", "\"str\"", "//c\n",
              "a&&b||c", "<=>=!="};
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0, 1, 2: send_text(words[$urandom_range(9)]);
        3: send_byte(pick_byte(), $urandom_range(30) == 0);
        default: send_byte(pick_byte(), 1'b0);
      endcase
    end
    send_byte(8'($urandom_range(255)), 1'b1);
  endtask

  initial begin
    lexer_sb = new();
    rst_ni = 0;
    s_axis_tvalid_i = 0; s_axis_tdata_i = 0; s_axis_tlast_i = 0;
    send_idle_pct = 6; recv_idle_pct = 58;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: keywords, numbers, literals, operators, comments and odd bytes.
    send_text("self if_ extern destruct\n12 3.4. 5.6.7 9a\n");
    send_text("'x' 'yz \"ab\" += && || /= ! ~;//c\x01\nz");
    send_byte(8'h80, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h2D, 1'b0); send_byte(8'h00, 1'b1);
    send_text("//end"); send_byte(8'hFF, 1'b1);
    send_text("'"); send_byte(8'h00, 1'b1);
    send_text("\"ab\ncd"); send_byte(8'h00, 1'b1);
    send_text("'q"); send_byte(8'h00, 1'b1);

    random_phase(40);
    send_idle_pct = 58; recv_idle_pct = 6;
    random_phase(40);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(40);
    s_axis_tvalid_i <= 1'b0;

    while (lexer_sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (lexer_sb.errors == 0) $display("** source_text_tokenizer_top: PASSED **");
    else $display("** source_text_tokenizer_top: FAILED **");
    $finish;
  end

endmodule
